[hw/rtl/nwfl_pkg.sv]
// ----------------------------------------------------------------------------
// nwfl_pkg
// Shared types and constants for the no-wait flow shop lateness evaluator.
// ----------------------------------------------------------------------------
package nwfl_pkg;

    localparam int TIME_W = 32;
    localparam int DUR_W  = 16;
    localparam int ID_W   = 16;
    localparam int MODE_W = 2;

    // Machine-two start can pass 2^32-1 by up to one op1 time.
    localparam int START_W = TIME_W + 1;
    // Start plus op2 time.
    localparam int REACH_W = TIME_W + 2;

    localparam int DOWNTIME_SLOTS = 16;
    localparam int SLOT_IDX_W     = (DOWNTIME_SLOTS > 1) ? $clog2(DOWNTIME_SLOTS) : 1;
    localparam int SLOT_CNT_W     = $clog2(DOWNTIME_SLOTS + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int IN_FIELDS_W  = 3 * TIME_W + ID_W + 2 * DUR_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = ID_W + 4 * TIME_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TASK   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        CMD_APPEND,
        CMD_TASK,
        CMD_CLEAR
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [TIME_W-1:0] down_start;
        logic [TIME_W-1:0] down_end;
        logic [ID_W-1:0]   task_id;
        logic [DUR_W-1:0]  op1_time;
        logic [DUR_W-1:0]  op2_time;
        logic [TIME_W-1:0] due_time;
        logic              last;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SETTLE,
        ST_DONE
    } t_state;

endpackage

[hw/rtl/no_wait_flowshop_lateness_eval_unit.sv]
// Scan: each blocking hit restarts the table scan from the first stored downtime
//   interval. Appends and clears are handled in the idle state without a scan.
// Throughput: one word at a time in the executor; the table scan reads one entry
//   per cycle from the downtime memory. A 2-word queue keeps input flowing.
// Reset: synchronous, active low; clears times, table count, queue and output.
// ----------------------------------------------------------------------------
// no_wait_flowshop_lateness_eval_unit
// Two-machine no-wait flow shop evaluator with machine-two downtime table.
// ----------------------------------------------------------------------------
module no_wait_flowshop_lateness_eval_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // down_start, down_end, task_id, op1_time, op2_time, due_time
    input  logic [nwfl_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // mode
    input  logic [nwfl_pkg::MODE_W-1:0]     i_s_tuser,
    input  logic                           i_s_tlast,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // task_id_res, m1_start, completion, lateness, max_lateness
    output logic [nwfl_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // overflow
    output logic                           o_m_tuser,
    output logic                           o_m_tlast
);
    import nwfl_pkg::*;

    t_cmd cmd;
    logic cmd_vld;
    logic cmd_pop;

    nwfl_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_cmd_vld  (cmd_vld),
        .o_cmd      (cmd),
        .i_cmd_pop  (cmd_pop)
    );

    nwfl_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_vld  (cmd_vld),
        .i_cmd      (cmd),
        .o_cmd_pop  (cmd_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

[hw/rtl/nwfl_front.sv]
// ----------------------------------------------------------------------------
// nwfl_front
// Accepts input words, classifies them by mode and queues commands.
// ----------------------------------------------------------------------------
module nwfl_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // down_start, down_end, task_id, op1_time, op2_time, due_time
    input  logic [nwfl_pkg::IN_DATA_W-1:0] i_s_tdata,
    // mode
    input  logic [nwfl_pkg::MODE_W-1:0]    i_s_tuser,
    input  logic                          i_s_tlast,
    output logic                          o_cmd_vld,
    output nwfl_pkg::t_cmd                o_cmd,
    input  logic                          i_cmd_pop
);
    import nwfl_pkg::*;

    t_cmd                   r_q [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_cnt, n_cnt;

    t_cmd cmd_in;
    logic keep;
    logic push;
    logic pop;

    always_comb begin
        cmd_in.down_start = i_s_tdata[31:0];
        cmd_in.down_end   = i_s_tdata[63:32];
        cmd_in.task_id    = i_s_tdata[79:64];
        cmd_in.op1_time   = i_s_tdata[95:80];
        cmd_in.op2_time   = i_s_tdata[111:96];
        cmd_in.due_time   = i_s_tdata[143:112];
        cmd_in.last       = i_s_tlast;
        keep              = 1'b1;
        unique case (i_s_tuser)
            MODE_APPEND: cmd_in.kind = CMD_APPEND;
            MODE_TASK:   cmd_in.kind = CMD_TASK;
            MODE_CLEAR:  cmd_in.kind = CMD_CLEAR;
            default: begin
                // unused mode: drop the word
                cmd_in.kind = CMD_APPEND;
                keep        = 1'b0;
            end
        endcase
    end

    assign o_s_tready = (r_cnt != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign push       = i_s_tvalid && o_s_tready && keep;
    assign o_cmd_vld  = (r_cnt != '0);
    assign pop        = i_cmd_pop && o_cmd_vld;
    assign o_cmd      = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                     : QUEUE_PTR_W'(r_wr_ptr + 1'b1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                     : QUEUE_PTR_W'(r_rd_ptr + 1'b1);
        end
        if (push && !pop) begin
            n_cnt = QUEUE_CNT_W'(r_cnt + 1'b1);
        end else if (pop && !push) begin
            n_cnt = QUEUE_CNT_W'(r_cnt - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

[hw/rtl/nwfl_back.sv]
// ----------------------------------------------------------------------------
// nwfl_back
// Executes queued commands: downtime table upkeep and task scheduling with
// a sequential table scan, then registers the result word.
// ----------------------------------------------------------------------------
module nwfl_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cmd_vld,
    input  nwfl_pkg::t_cmd                 i_cmd,
    output logic                           o_cmd_pop,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // task_id_res, m1_start, completion, lateness, max_lateness
    output logic [nwfl_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // overflow
    output logic                           o_m_tuser,
    output logic                           o_m_tlast
);
    import nwfl_pkg::*;

    // Downtime table, read one entry per cycle during the scan
    logic [TIME_W-1:0] mem_start [DOWNTIME_SLOTS];
    logic [TIME_W-1:0] mem_end   [DOWNTIME_SLOTS];
    logic [TIME_W-1:0] r_rd_start;
    logic [TIME_W-1:0] r_rd_end;
    logic              mem_we;

    t_state                r_state, n_state;
    logic [SLOT_CNT_W-1:0] r_count, n_count;
    logic [SLOT_CNT_W-1:0] r_idx, n_idx;
    logic                  r_cmp_vld, n_cmp_vld;
    logic [TIME_W-1:0]     r_m1_free, n_m1_free;
    logic [TIME_W-1:0]     r_m2_free, n_m2_free;
    logic [TIME_W-1:0]     r_max_late, n_max_late;
    logic                  r_out_vld, n_out_vld;

    t_cmd                  r_task, n_task;
    logic [START_W-1:0]    r_s2, n_s2;
    logic [TIME_W-1:0]     r_comp, n_comp;
    logic [TIME_W-1:0]     r_m1n, n_m1n;
    logic [TIME_W-1:0]     r_m1_start, n_m1_start;
    logic                  r_ovf, n_ovf;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;
    logic                  r_out_ovf, n_out_ovf;
    logic                  r_out_last, n_out_last;

    logic [START_W-1:0] ready_at;
    logic [START_W-1:0] m2_wide;
    logic [REACH_W-1:0] reach;
    logic               hit;
    logic [TIME_W-1:0]  late;
    logic [TIME_W-1:0]  max_new;

    assign ready_at = START_W'(r_m1_free) + START_W'(i_cmd.op1_time);
    assign m2_wide  = START_W'(r_m2_free);
    assign reach    = REACH_W'(r_s2) + REACH_W'(r_task.op2_time);
    assign hit      = r_cmp_vld && (reach > REACH_W'(r_rd_start))
                   && (r_s2 < START_W'(r_rd_end));
    assign late     = (r_comp > r_task.due_time) ? TIME_W'(r_comp - r_task.due_time) : '0;
    assign max_new  = (late > r_max_late) ? late : r_max_late;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_cmp_vld  = r_cmp_vld;
        n_m1_free  = r_m1_free;
        n_m2_free  = r_m2_free;
        n_max_late = r_max_late;
        n_out_vld  = r_out_vld && !i_m_tready;
        n_task     = r_task;
        n_s2       = r_s2;
        n_comp     = r_comp;
        n_m1n      = r_m1n;
        n_m1_start = r_m1_start;
        n_ovf      = r_ovf;
        n_out_data = r_out_data;
        n_out_ovf  = r_out_ovf;
        n_out_last = r_out_last;
        o_cmd_pop  = 1'b0;
        mem_we     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_cmd_pop = 1'b1;
                if (i_cmd_vld) begin
                    unique case (i_cmd.kind)
                        CMD_APPEND: begin
                            // full table: drop the append
                            if (r_count < SLOT_CNT_W'(DOWNTIME_SLOTS)) begin
                                mem_we  = 1'b1;
                                n_count = SLOT_CNT_W'(r_count + 1'b1);
                            end
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        CMD_TASK: begin
                            n_task    = i_cmd;
                            n_s2      = (ready_at < m2_wide) ? m2_wide : ready_at;
                            n_idx     = '0;
                            n_cmp_vld = 1'b0;
                            n_state   = ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    // jump past the blocking interval and rescan from the top
                    n_s2      = START_W'(r_rd_end);
                    n_idx     = '0;
                    n_cmp_vld = 1'b0;
                end else if (r_idx < r_count) begin
                    n_idx     = SLOT_CNT_W'(r_idx + 1'b1);
                    n_cmp_vld = 1'b1;
                end else begin
                    n_cmp_vld = 1'b0;
                    n_state   = ST_SETTLE;
                end
            end
            ST_SETTLE: begin
                n_ovf = 1'b0;
                if (reach > REACH_W'(TIME_MAX)) begin
                    n_comp = TIME_MAX;
                    n_ovf  = 1'b1;
                end else begin
                    n_comp = TIME_W'(reach);
                end
                if (r_s2[TIME_W]) begin
                    n_m1n = TIME_MAX;
                    n_ovf = 1'b1;
                end else begin
                    n_m1n = TIME_W'(r_s2);
                end
                n_m1_start = TIME_W'(r_s2 - START_W'(r_task.op1_time));
                n_state    = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!r_out_vld || i_m_tready) begin
                    n_out_vld  = 1'b1;
                    n_out_data = OUT_DATA_W'({max_new, late, r_comp, r_m1_start,
                                              r_task.task_id});
                    n_out_ovf  = r_ovf;
                    n_out_last = r_task.last;
                    if (r_task.last) begin
                        n_m1_free  = '0;
                        n_m2_free  = '0;
                        n_max_late = '0;
                    end else begin
                        n_m1_free  = r_m1n;
                        n_m2_free  = r_comp;
                        n_max_late = max_new;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_idx      <= '0;
            r_cmp_vld  <= 1'b0;
            r_m1_free  <= '0;
            r_m2_free  <= '0;
            r_max_late <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_idx      <= n_idx;
            r_cmp_vld  <= n_cmp_vld;
            r_m1_free  <= n_m1_free;
            r_m2_free  <= n_m2_free;
            r_max_late <= n_max_late;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_task     <= n_task;
        r_s2       <= n_s2;
        r_comp     <= n_comp;
        r_m1n      <= n_m1n;
        r_m1_start <= n_m1_start;
        r_ovf      <= n_ovf;
        r_out_data <= n_out_data;
        r_out_ovf  <= n_out_ovf;
        r_out_last <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_start[r_count[SLOT_IDX_W-1:0]] <= i_cmd.down_start;
            mem_end[r_count[SLOT_IDX_W-1:0]]   <= i_cmd.down_end;
        end
        r_rd_start <= mem_start[r_idx[SLOT_IDX_W-1:0]];
        r_rd_end   <= mem_end[r_idx[SLOT_IDX_W-1:0]];
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_ovf;
    assign o_m_tlast  = r_out_last;

endmodule

[sim/tb_no_wait_flowshop_lateness_eval_unit.sv]
// ----------------------------------------------------------------------------
// tb_no_wait_flowshop_lateness_eval_unit
// Self-checking bench for the no-wait flow shop lateness evaluator. It drives
// downtime appends, clears, tasks and unused words through the input stream.
// A built-in schedule predictor, with its own copy of the free times and the
// downtime table, computes each expected result word. Results are checked
// field by field as they arrive, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_no_wait_flowshop_lateness_eval_unit;

    import nwfl_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_WORDS   = 1240;
    localparam int TAIL_WORDS     = 60;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [TIME_W-1:0] down_start;
        logic [TIME_W-1:0] down_end;
        logic [ID_W-1:0]   task_id;
        logic [DUR_W-1:0]  op1_time;
        logic [DUR_W-1:0]  op2_time;
        logic [TIME_W-1:0] due_time;
        logic              last;
    } t_sched_word;

    typedef struct packed {
        logic [ID_W-1:0]   task_id;
        logic [TIME_W-1:0] m1_start;
        logic [TIME_W-1:0] completion;
        logic [TIME_W-1:0] lateness;
        logic [TIME_W-1:0] max_lateness;
        logic              last;
        logic              overflow;
    } t_sched_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [MODE_W-1:0]     s_tuser = MODE_UNUSED;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    // predictor state
    logic [TIME_W-1:0] m1_free;
    logic [TIME_W-1:0] m2_free;
    logic [TIME_W-1:0] worst_late;
    logic [TIME_W-1:0] dt_start [DOWNTIME_SLOTS];
    logic [TIME_W-1:0] dt_end   [DOWNTIME_SLOTS];
    int unsigned       dt_count;

    t_sched_result sched_expect_q[$];

    int errors      = 0;
    int words_sent  = 0;
    int quiet_count = 0;
    int hold_left   = 0;
    int stall_left  = 0;
    bit hold_req    = 1'b0;
    bit src_gaps_on = 1'b1;
    bit sink_stalls_on = 1'b1;

    always #4 i_clk = ~i_clk;

    no_wait_flowshop_lateness_eval_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    // ------------------------------------------------------------------------
    // schedule predictor
    // ------------------------------------------------------------------------
    task automatic predict_schedule(input t_sched_word w);
        logic [63:0]   start2;
        logic [63:0]   comp;
        logic [63:0]   m1_next;
        logic [63:0]   late;
        logic [63:0]   m1_begin;
        logic          hit;
        t_sched_result r;
        case (w.mode)
            MODE_APPEND: begin
                if (dt_count < DOWNTIME_SLOTS) begin
                    dt_start[dt_count] = w.down_start;
                    dt_end[dt_count]   = w.down_end;
                    dt_count++;
                end
            end
            MODE_CLEAR: dt_count = 0;
            MODE_TASK: begin
                r.overflow = 1'b0;
                start2 = 64'(m1_free) + 64'(w.op1_time);
                if (start2 < 64'(m2_free))
                    start2 = 64'(m2_free);
                // jump to the end of the first blocking interval, then rescan
                do begin
                    hit = 1'b0;
                    for (int i = 0; i < dt_count; i++) begin
                        if (!hit && start2 + 64'(w.op2_time) > 64'(dt_start[i])
                                && start2 < 64'(dt_end[i])) begin
                            hit    = 1'b1;
                            start2 = 64'(dt_end[i]);
                        end
                    end
                end while (hit);
                comp = start2 + 64'(w.op2_time);
                if (comp > 64'(TIME_MAX)) begin
                    comp = 64'(TIME_MAX);
                    r.overflow = 1'b1;
                end
                m1_next = start2;
                if (m1_next > 64'(TIME_MAX)) begin
                    m1_next = 64'(TIME_MAX);
                    r.overflow = 1'b1;
                end
                late = (comp > 64'(w.due_time)) ? comp - 64'(w.due_time) : 64'd0;
                if (late > 64'(worst_late))
                    worst_late = late[TIME_W-1:0];
                m1_begin       = start2 - 64'(w.op1_time);
                r.task_id      = w.task_id;
                r.m1_start     = m1_begin[TIME_W-1:0];
                r.completion   = comp[TIME_W-1:0];
                r.lateness     = late[TIME_W-1:0];
                r.max_lateness = worst_late;
                r.last         = w.last;
                sched_expect_q = {sched_expect_q, r};
                m1_free = m1_next[TIME_W-1:0];
                m2_free = comp[TIME_W-1:0];
                if (w.last) begin
                    m1_free    = '0;
                    m2_free    = '0;
                    worst_late = '0;
                end
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // word builders
    // ------------------------------------------------------------------------
    function automatic t_sched_word append_word(input logic [TIME_W-1:0] ds,
                                                input logic [TIME_W-1:0] de);
        t_sched_word w;
        w            = '0;
        w.mode       = MODE_APPEND;
        w.down_start = ds;
        w.down_end   = de;
        return w;
    endfunction

    function automatic t_sched_word clear_word();
        t_sched_word w;
        w      = '0;
        w.mode = MODE_CLEAR;
        return w;
    endfunction

    function automatic t_sched_word task_word(input logic [ID_W-1:0]   id,
                                              input logic [DUR_W-1:0]  p1,
                                              input logic [DUR_W-1:0]  p2,
                                              input logic [TIME_W-1:0] due,
                                              input logic              last);
        t_sched_word w;
        w          = '0;
        w.mode     = MODE_TASK;
        w.task_id  = id;
        w.op1_time = p1;
        w.op2_time = p2;
        w.due_time = due;
        w.last     = last;
        return w;
    endfunction

    function automatic logic [DUR_W-1:0] rand_duration();
        if ($urandom_range(0, 7) == 0)
            return DUR_W'($urandom);
        if ($urandom_range(0, 9) == 0)
            return '0;
        return DUR_W'($urandom_range(0, 3000));
    endfunction

    function automatic t_sched_word rand_task(input logic last);
        logic [TIME_W-1:0] due;
        due = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 30000);
        return task_word(ID_W'($urandom), rand_duration(), rand_duration(), due, last);
    endfunction

    function automatic t_sched_word rand_interval();
        logic [TIME_W-1:0] ds;
        int unsigned       pick;
        pick = $urandom_range(0, 15);
        ds   = $urandom_range(0, 30000);
        if (pick < 2)
            return append_word($urandom, $urandom);
        if (pick == 2)
            return append_word(ds, ds);
        if (pick == 3)
            return append_word(ds, ds - $urandom_range(1, 2000));
        return append_word(ds, ds + $urandom_range(1, 3000));
    endfunction

    function automatic t_sched_word rand_noise();
        t_sched_word w;
        w            = '0;
        w.mode       = MODE_UNUSED;
        w.down_start = $urandom;
        w.down_end   = $urandom;
        w.task_id    = ID_W'($urandom);
        w.op1_time   = DUR_W'($urandom);
        w.op2_time   = DUR_W'($urandom);
        w.due_time   = $urandom;
        w.last       = 1'($urandom);
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // sender: optional gap burst, then hold the word until accepted
    // ------------------------------------------------------------------------
    task automatic send_word(input t_sched_word w);
        int gap;
        if (src_gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            repeat (gap) begin
                @(negedge i_clk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tuser  <= w.mode;
        s_tlast  <= w.last;
        s_tdata  <= IN_DATA_W'({w.due_time, w.op2_time, w.op1_time, w.task_id,
                                w.down_end, w.down_start});
        do @(posedge i_clk); while (!s_tready);
        predict_schedule(w);
        words_sent++;
    endtask

    // ------------------------------------------------------------------------
    // receiver: random stall bursts and an optional long hold-off
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (sink_stalls_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 14);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------------
    task automatic check_field(input string fname, input logic [TIME_W-1:0] exp_v,
                               input logic [TIME_W-1:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, fname, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_sched_result want;
        t_sched_result got;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.task_id      = m_tdata[15:0];
            got.m1_start     = m_tdata[47:16];
            got.completion   = m_tdata[79:48];
            got.lateness     = m_tdata[111:80];
            got.max_lateness = m_tdata[143:112];
            got.last         = m_tlast;
            got.overflow     = m_tuser;
            if (sched_expect_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word, expected none, actual %0h",
                         $time, got);
            end else begin
                want = sched_expect_q.pop_front();
                check_field("task_id",      TIME_W'(want.task_id), TIME_W'(got.task_id));
                check_field("m1_start",     want.m1_start,     got.m1_start);
                check_field("completion",   want.completion,   got.completion);
                check_field("lateness",     want.lateness,     got.lateness);
                check_field("max_lateness", want.max_lateness, got.max_lateness);
                check_field("last",         TIME_W'(want.last), TIME_W'(got.last));
                check_field("overflow",     TIME_W'(want.overflow), TIME_W'(got.overflow));
            end
        end
    end

    // watchdog: count cycles in which neither side moves a word
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_count = 0;
        else
            quiet_count++;
        if (quiet_count >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_downtime_edges();
        send_word(clear_word());
        send_word(append_word(32'd100, 32'd200));
        send_word(append_word(32'd1000, 32'd500));     // reversed interval
        send_word(append_word(32'd50, 32'd50));        // empty interval
        send_word(task_word(16'd0, 16'd0, 16'd0, 32'd0, 1'b0));
        send_word(task_word(16'd1, 16'd100, 16'd0, 32'd1000, 1'b0));
        send_word(task_word(16'd2, 16'd50, 16'd0, 32'd0, 1'b0));
        send_word(task_word(16'd3, 16'd0, 16'd600, 32'd10, 1'b0));
        send_word(task_word('1, '1, '1, TIME_MAX, 1'b1));
    endtask

    task automatic test_ignored_mode();
        t_sched_word w;
        w      = '1;
        w.mode = MODE_UNUSED;
        send_word(w);
    endtask

    task automatic test_table_full();
        // descending chain forces a rescan after every jump
        for (int k = 12; k >= 0; k--)
            send_word(append_word(32'd1000 + 10 * k, 32'd1010 + 10 * k));
        send_word(append_word(TIME_MAX, TIME_MAX));    // table full: dropped
        send_word(task_word(16'h00aa, 16'd1000, 16'd5, 32'd900, 1'b1));
    endtask

    task automatic test_saturation();
        send_word(clear_word());
        send_word(append_word(32'd0, 32'hffff_fff0));
        send_word(task_word(16'h0101, 16'h0020, 16'h0100, 32'd0, 1'b0));
        send_word(task_word(16'h0102, 16'h0100, 16'h0000, 32'd5, 1'b1));
        send_word(clear_word());
    endtask

    task automatic test_backpressure();
        src_gaps_on = 1'b0;
        hold_req    = 1'b1;
        send_word(append_word(32'd400, 32'd450));
        for (int k = 0; k < 20; k++)
            send_word(task_word(16'(k), 16'($urandom_range(0, 200)),
                                16'($urandom_range(0, 200)),
                                $urandom_range(0, 3000), k == 19));
        src_gaps_on = 1'b1;
    endtask

    task automatic test_random_permutations(input int target, input bit vary_idle);
        int n_append;
        int n_task;
        while (words_sent < target) begin
            if (vary_idle) begin
                src_gaps_on    = ($urandom_range(0, 3) != 0);
                sink_stalls_on = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 2) == 0)
                send_word(clear_word());
            n_append = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20)
                                                   : $urandom_range(0, 4);
            repeat (n_append) send_word(rand_interval());
            n_task = $urandom_range(1, 12);
            for (int k = 0; k < n_task; k++) begin
                if ($urandom_range(0, 15) == 0)
                    send_word(rand_noise());
                // some permutations are left open and run into the next one
                send_word(rand_task(k == n_task - 1 && $urandom_range(0, 7) != 0));
            end
        end
    endtask

    task automatic test_no_idle_tail();
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        test_random_permutations(words_sent + TAIL_WORDS, 1'b0);
    endtask

    initial begin
        m1_free    = '0;
        m2_free    = '0;
        worst_late = '0;
        dt_count   = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_downtime_edges();
        test_ignored_mode();
        test_table_full();
        test_saturation();
        test_backpressure();
        test_random_permutations(RANDOM_WORDS, 1'b1);
        test_no_idle_tail();

        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (sched_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
